### hw/rtl/pfcs_pkg.sv
// Package: shared widths, types, codes and bus constants of the flash command sequencer.
package pfcs_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STABLE_W = 20;
    localparam int unsigned CHANGE_W = 26;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [1:0]          cmd_t;
    typedef logic [1:0]          lane_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [DATA_W-1:0]   word_t;
    typedef logic [STABLE_W-1:0] stable_t;
    typedef logic [CHANGE_W-1:0] change_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // command codes
    localparam cmd_t CMD_ERASE   = 2'd0;
    localparam cmd_t CMD_PROGRAM = 2'd1;
    localparam cmd_t CMD_SAMPLE  = 2'd2;

    // result kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // configuration register indexes
    localparam cfg_idx_t CFG_FLASH_BASE   = 2'd0;
    localparam cfg_idx_t CFG_STABLE_READS = 2'd1;
    localparam cfg_idx_t CFG_CHANGE_LIMIT = 2'd2;

    // configuration reset values
    localparam addr_t   FLASH_BASE_RST   = 32'hBC00_0000;
    localparam stable_t STABLE_READS_RST = 20'd100000;
    localparam change_t CHANGE_LIMIT_RST = 26'd30000000;

    // unlock / command cycles
    localparam addr_t UNLOCK1_OFS   = 32'h0000_0AA8;
    localparam word_t UNLOCK1_DAT   = 32'hAAAA_AAAA;
    localparam addr_t UNLOCK2_OFS   = 32'h0000_0554;
    localparam word_t UNLOCK2_DAT   = 32'h5555_5555;
    localparam word_t PROG_SETUP    = 32'hA0A0_A0A0;
    localparam word_t ERASE_SETUP   = 32'h8080_8080;
    localparam word_t ERASE_CONFIRM = 32'h3030_3030;

    localparam lane_t LANE_UNLOCK1 = 2'd2;
    localparam lane_t LANE_UNLOCK2 = 2'd1;
    localparam lane_t LANE_SECTOR  = 2'd0;

    localparam word_t SAMPLE_RST = 32'h0000_00FF;

endpackage

### hw/rtl/pfcs_if.sv
// Interfaces: command channel and result channel of the flash command sequencer.
interface pfcs_req_if;
    import pfcs_pkg::*;

    logic  valid;
    logic  ready;
    cmd_t  cmd;
    addr_t target_addr;
    word_t data_in;
    word_t sample;

    modport source (output valid, cmd, target_addr, data_in, sample, input ready);
    modport sink   (input valid, cmd, target_addr, data_in, sample, output ready);
endinterface

interface pfcs_rsp_if;
    import pfcs_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    lane_t lane;
    addr_t bus_addr;
    word_t bus_data;
    logic  timed_out;
    logic  last;

    modport source (output valid, kind, lane, bus_addr, bus_data, timed_out, last,
                    input ready);
    modport sink   (input valid, kind, lane, bus_addr, bus_data, timed_out, last,
                    output ready);
endinterface

### hw/rtl/parallel_flash_command_sequencer.sv
// Top level: NOR flash program/erase command sequencer with status polling.
//
// Channels: req carries commands (erase, program word, status sample) and
// rsp carries results, one beat per result: bus write cycles to issue on
// the 32-bit flash bus (with byte lane) and a finish beat with the timeout
// flag. The beat marked last closes the results of one command beat.
// The cfg port writes flash_base, stable_reads and change_limit; write only
// while the block is idle.
//
// Latency: results of an accepted command start on the next cycle and then
// leave one per cycle while rsp is ready: an erase gives 6 writes, each
// program byte 4, a poll end 4 writes (next byte) or 1 finish beat.
// Throughput: a command beat is taken every cycle while no result burst is
// pending, so status samples flow at one per cycle; a result burst blocks
// req, since the burst register is the only result store and req reopens
// on the cycle the final beat leaves.
//
// Reset: configuration returns to its defaults, the sequencer goes idle and
// no result is pending. When the receiver stalls rsp, the pending beat holds
// and req stays low until the burst's final beat is taken.
module parallel_flash_command_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  pfcs_pkg::cfg_idx_t  cfg_index,
    input  pfcs_pkg::word_t     cfg_wdata,
    pfcs_req_if.sink            req,
    pfcs_rsp_if.source          rsp
);
    import pfcs_pkg::*;

    typedef enum logic {PH_IDLE, PH_POLL} phase_t;
    typedef enum logic [1:0] {BST_ERASE, BST_BYTE, BST_FINISH} burst_t;

    // configuration
    addr_t   flash_base_reg,   flash_base_next;
    stable_t stable_reads_reg, stable_reads_next;
    change_t change_limit_reg, change_limit_next;

    // operation state
    phase_t  phase_reg,        phase_next;
    logic    op_is_program_reg, op_is_program_next;
    lane_t   byte_index_reg,   byte_index_next;
    addr_t   held_addr_reg,    held_addr_next;
    word_t   held_word_reg,    held_word_next;
    word_t   last_sample_reg,  last_sample_next;
    stable_t stable_count_reg, stable_count_next;
    change_t change_count_reg, change_count_next;
    logic    timeout_seen_reg, timeout_seen_next;

    // result burst register: one descriptor, walked one beat per cycle while rsp is ready
    logic    bst_valid_reg,    bst_valid_next;
    burst_t  bst_kind_reg,     bst_kind_next;
    logic [2:0] bst_beat_reg,  bst_beat_next;
    addr_t   bst_addr_reg,     bst_addr_next;
    logic [7:0] bst_byte_reg,  bst_byte_next;
    lane_t   bst_lane_reg,     bst_lane_next;
    logic    bst_tmo_reg,      bst_tmo_next;

    logic    bst_final;
    logic    rsp_take;
    logic    req_take;

    // poll arithmetic
    logic                changed;
    logic [STABLE_W:0]   sc_inc;
    logic [CHANGE_W:0]   cc_inc;
    logic                poll_done;
    logic                poll_tmo;
    lane_t               next_lane;

    addr_t               unlock1_addr;
    addr_t               unlock2_addr;

    always_comb
    begin
        unique case (bst_kind_reg)
            BST_ERASE:  bst_final = (bst_beat_reg == 3'd5);
            BST_BYTE:   bst_final = (bst_beat_reg == 3'd3);
            BST_FINISH: bst_final = 1'b1;
            default:    bst_final = 1'b1;
        endcase
    end

    // reopen req on the cycle the final beat of a burst leaves
    assign rsp_take  = bst_valid_reg && rsp.ready;
    assign req.ready = !bst_valid_reg || (rsp.ready && bst_final);
    assign req_take  = req.valid && req.ready;

    assign changed   = (req.sample != last_sample_reg);
    assign sc_inc    = changed ? (STABLE_W+1)'(1) : ({1'b0, stable_count_reg} + 1'b1);
    assign cc_inc    = {1'b0, change_count_reg} + (CHANGE_W+1)'(changed);
    assign poll_done = sc_inc > {1'b0, stable_reads_reg};
    assign poll_tmo  = !poll_done && (cc_inc > {1'b0, change_limit_reg});
    assign next_lane = byte_index_reg + 2'd1;

    always_comb
    begin
        flash_base_next    = flash_base_reg;
        stable_reads_next  = stable_reads_reg;
        change_limit_next  = change_limit_reg;
        phase_next         = phase_reg;
        op_is_program_next = op_is_program_reg;
        byte_index_next    = byte_index_reg;
        held_addr_next     = held_addr_reg;
        held_word_next     = held_word_reg;
        last_sample_next   = last_sample_reg;
        stable_count_next  = stable_count_reg;
        change_count_next  = change_count_reg;
        timeout_seen_next  = timeout_seen_reg;
        bst_valid_next     = bst_valid_reg;
        bst_kind_next      = bst_kind_reg;
        bst_beat_next      = bst_beat_reg;
        bst_addr_next      = bst_addr_reg;
        bst_byte_next      = bst_byte_reg;
        bst_lane_next      = bst_lane_reg;
        bst_tmo_next       = bst_tmo_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FLASH_BASE:   flash_base_next   = cfg_wdata;
                CFG_STABLE_READS: stable_reads_next = cfg_wdata[STABLE_W-1:0];
                CFG_CHANGE_LIMIT: change_limit_next = cfg_wdata[CHANGE_W-1:0];
                default:          ;
            endcase
        end

        // advance or drop the pending burst
        if (rsp_take)
        begin
            if (bst_final)
                bst_valid_next = 1'b0;
            else
                bst_beat_next = bst_beat_reg + 3'd1;
        end

        if (req_take)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (req.cmd == CMD_ERASE || req.cmd == CMD_PROGRAM)
                begin
                    op_is_program_next = (req.cmd == CMD_PROGRAM);
                    held_addr_next     = req.target_addr;
                    timeout_seen_next  = 1'b0;
                    phase_next         = PH_POLL;
                    last_sample_next   = SAMPLE_RST;
                    stable_count_next  = '0;
                    change_count_next  = '0;
                    bst_valid_next     = 1'b1;
                    bst_beat_next      = 3'd0;
                    bst_addr_next      = req.target_addr;
                    bst_tmo_next       = 1'b0;
                    if (req.cmd == CMD_PROGRAM)
                    begin
                        held_word_next  = req.data_in;
                        byte_index_next = 2'd0;
                        bst_kind_next   = BST_BYTE;
                        bst_lane_next   = 2'd0;
                        bst_byte_next   = req.data_in[7:0];
                    end
                    else
                    begin
                        bst_kind_next = BST_ERASE;
                        bst_lane_next = LANE_SECTOR;
                        bst_byte_next = '0;
                    end
                end
            end
            else if (req.cmd == CMD_SAMPLE)
            begin
                last_sample_next = req.sample;
                if (!poll_done && !poll_tmo)
                begin
                    stable_count_next = sc_inc[STABLE_W-1:0];
                    change_count_next = cc_inc[CHANGE_W-1:0];
                end
                else
                begin
                    stable_count_next = '0;
                    change_count_next = '0;
                    if (poll_tmo)
                        timeout_seen_next = 1'b1;
                    bst_valid_next = 1'b1;
                    bst_beat_next  = 3'd0;
                    if (op_is_program_reg && byte_index_reg != 2'd3)
                    begin
                        // next byte of the word, lowest first
                        byte_index_next  = next_lane;
                        last_sample_next = SAMPLE_RST;
                        bst_kind_next    = BST_BYTE;
                        bst_lane_next    = next_lane;
                        bst_addr_next    = held_addr_reg;
                        bst_byte_next    = held_word_reg[8*next_lane +: 8];
                        bst_tmo_next     = 1'b0;
                    end
                    else
                    begin
                        phase_next    = PH_IDLE;
                        bst_kind_next = BST_FINISH;
                        bst_lane_next = '0;
                        bst_addr_next = '0;
                        bst_byte_next = '0;
                        bst_tmo_next  = timeout_seen_reg || poll_tmo;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_base_reg    <= FLASH_BASE_RST;
            stable_reads_reg  <= STABLE_READS_RST;
            change_limit_reg  <= CHANGE_LIMIT_RST;
            phase_reg         <= PH_IDLE;
            op_is_program_reg <= 1'b0;
            byte_index_reg    <= '0;
            held_addr_reg     <= '0;
            held_word_reg     <= '0;
            last_sample_reg   <= SAMPLE_RST;
            stable_count_reg  <= '0;
            change_count_reg  <= '0;
            timeout_seen_reg  <= 1'b0;
            bst_valid_reg     <= 1'b0;
            bst_kind_reg      <= BST_FINISH;
            bst_beat_reg      <= '0;
            bst_addr_reg      <= '0;
            bst_byte_reg      <= '0;
            bst_lane_reg      <= '0;
            bst_tmo_reg       <= 1'b0;
        end
        else
        begin
            flash_base_reg    <= flash_base_next;
            stable_reads_reg  <= stable_reads_next;
            change_limit_reg  <= change_limit_next;
            phase_reg         <= phase_next;
            op_is_program_reg <= op_is_program_next;
            byte_index_reg    <= byte_index_next;
            held_addr_reg     <= held_addr_next;
            held_word_reg     <= held_word_next;
            last_sample_reg   <= last_sample_next;
            stable_count_reg  <= stable_count_next;
            change_count_reg  <= change_count_next;
            timeout_seen_reg  <= timeout_seen_next;
            bst_valid_reg     <= bst_valid_next;
            bst_kind_reg      <= bst_kind_next;
            bst_beat_reg      <= bst_beat_next;
            bst_addr_reg      <= bst_addr_next;
            bst_byte_reg      <= bst_byte_next;
            bst_lane_reg      <= bst_lane_next;
            bst_tmo_reg       <= bst_tmo_next;
        end
    end

    // decode current beat; user keeps base stable while busy, not enforced
    assign unlock1_addr = flash_base_reg + UNLOCK1_OFS;
    assign unlock2_addr = flash_base_reg + UNLOCK2_OFS;

    always_comb
    begin
        rsp.kind      = KIND_WRITE;
        rsp.lane      = LANE_UNLOCK1;
        rsp.bus_addr  = unlock1_addr;
        rsp.bus_data  = UNLOCK1_DAT;
        rsp.timed_out = 1'b0;
        unique case (bst_kind_reg)
            BST_ERASE:
            begin
                case (bst_beat_reg)
                    3'd1, 3'd4:
                    begin
                        rsp.lane     = LANE_UNLOCK2;
                        rsp.bus_addr = unlock2_addr;
                        rsp.bus_data = UNLOCK2_DAT;
                    end
                    3'd2:    rsp.bus_data = ERASE_SETUP;
                    3'd5:
                    begin
                        rsp.lane     = LANE_SECTOR;
                        rsp.bus_addr = bst_addr_reg;
                        rsp.bus_data = ERASE_CONFIRM;
                    end
                    default: ;
                endcase
            end
            BST_BYTE:
            begin
                case (bst_beat_reg)
                    3'd1:
                    begin
                        rsp.lane     = LANE_UNLOCK2;
                        rsp.bus_addr = unlock2_addr;
                        rsp.bus_data = UNLOCK2_DAT;
                    end
                    3'd2:    rsp.bus_data = PROG_SETUP;
                    3'd3:
                    begin
                        rsp.lane     = bst_lane_reg;
                        rsp.bus_addr = bst_addr_reg;
                        rsp.bus_data = {24'd0, bst_byte_reg};
                    end
                    default: ;
                endcase
            end
            default:
            begin
                rsp.kind      = KIND_FINISH;
                rsp.lane      = '0;
                rsp.bus_addr  = '0;
                rsp.bus_data  = '0;
                rsp.timed_out = bst_tmo_reg;
            end
        endcase
    end

    assign rsp.valid = bst_valid_reg;
    assign rsp.last  = bst_final;

endmodule

### hw/rtl/pfcs_checker.sv
// Checker: port-level assertions for the flash command sequencer, bound to the top level.
module pfcs_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input logic            rsp_kind,
    input pfcs_pkg::lane_t rsp_lane,
    input pfcs_pkg::addr_t rsp_bus_addr,
    input pfcs_pkg::word_t rsp_bus_data,
    input logic            rsp_timed_out,
    input logic            rsp_last
);
    import pfcs_pkg::*;

    // hold a stalled beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bus_addr)
            && $stable(rsp_bus_data) && $stable(rsp_kind) && $stable(rsp_last))
        else $error("stalled result beat changed");

    // a stalled result keeps the command side closed
    a_stall_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("command taken while result stalled");

    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_FINISH |-> rsp_last)
        else $error("finish beat not marked last");

    a_finish_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_FINISH |->
            rsp_lane == '0 && rsp_bus_addr == '0 && rsp_bus_data == '0)
        else $error("finish beat carries bus fields");

    a_write_no_tmo: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_WRITE |-> !rsp_timed_out)
        else $error("write beat flags timeout");

endmodule

bind parallel_flash_command_sequencer pfcs_checker u_pfcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_kind      (rsp.kind),
    .rsp_lane      (rsp.lane),
    .rsp_bus_addr  (rsp.bus_addr),
    .rsp_bus_data  (rsp.bus_data),
    .rsp_timed_out (rsp.timed_out),
    .rsp_last      (rsp.last)
);

### tb/parallel_flash_command_sequencer_test.sv
// Self-checking testbench for the NOR flash program/erase command sequencer.
`timescale 1ns / 100ps

module parallel_flash_command_sequencer_test;
    import pfcs_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int   LIMIT_CYCLES  = 1_000_000; // hard stop, far above a clean run
    localparam int   SETTLE_CYCLES = 8;         // quiet cycles after the last result
    localparam int   HOLD_CYCLES   = 400;       // long receiver hold-off
    localparam cmd_t CMD_NONE      = 2'd3;      // code the block must always ignore

    typedef enum logic {SEQ_IDLE, SEQ_POLL} seq_phase_t;

    // One result beat, field for field as it leaves the rsp channel.
    typedef struct packed {
        logic  kind;
        lane_t lane;
        addr_t bus_addr;
        word_t bus_data;
        logic  timed_out;
        logic  last;
    } flash_result_t;

    // One row of directed stimulus. A row may repeat its beat; where the
    // expectation is typed in, it applies to the final repeat only.
    typedef struct packed {
        cmd_t        cmd;
        addr_t       taddr;
        word_t       wdata;
        word_t       status;
        logic [16:0] reps;
        logic        reconfig;  // drain and load the next directed setting first
        logic        typed;     // take results from TYPED_RESULTS, not the predictor
        logic [3:0]  first;
        logic [2:0]  count;
    } stim_row_t;

    typedef struct packed {
        addr_t   base;
        stable_t stable;
        change_t change;
    } cfg_set_t;

    // ------------------------------------------------------------------
    // Typed expectations: values that follow straight from the command
    // layout, with no poll bookkeeping involved.
    // ------------------------------------------------------------------
    localparam flash_result_t TYPED_RESULTS [16] = '{
        // erase at reset base 0xBC000000, sector at the top of the space
        '{KIND_WRITE, LANE_UNLOCK1, 32'hBC00_0AA8, UNLOCK1_DAT,   1'b0, 1'b0},
        '{KIND_WRITE, LANE_UNLOCK2, 32'hBC00_0554, UNLOCK2_DAT,   1'b0, 1'b0},
        '{KIND_WRITE, LANE_UNLOCK1, 32'hBC00_0AA8, ERASE_SETUP,   1'b0, 1'b0},
        '{KIND_WRITE, LANE_UNLOCK1, 32'hBC00_0AA8, UNLOCK1_DAT,   1'b0, 1'b0},
        '{KIND_WRITE, LANE_UNLOCK2, 32'hBC00_0554, UNLOCK2_DAT,   1'b0, 1'b0},
        '{KIND_WRITE, LANE_SECTOR,  32'hFFFF_FFFF, ERASE_CONFIRM, 1'b0, 1'b1},
        // clean finish
        '{KIND_FINISH, 2'd0, 32'h0, 32'h0, 1'b0, 1'b1},
        // program byte 0 with base 0xFFFFFFFF: unlock addresses wrap
        '{KIND_WRITE, LANE_UNLOCK1, 32'h0000_0AA7, UNLOCK1_DAT, 1'b0, 1'b0},
        '{KIND_WRITE, LANE_UNLOCK2, 32'h0000_0553, UNLOCK2_DAT, 1'b0, 1'b0},
        '{KIND_WRITE, LANE_UNLOCK1, 32'h0000_0AA7, PROG_SETUP,  1'b0, 1'b0},
        '{KIND_WRITE, 2'd0,         32'h0000_0000, 32'h0000_00FF, 1'b0, 1'b1},
        // program byte 1, same word
        '{KIND_WRITE, LANE_UNLOCK1, 32'h0000_0AA7, UNLOCK1_DAT, 1'b0, 1'b0},
        '{KIND_WRITE, LANE_UNLOCK2, 32'h0000_0553, UNLOCK2_DAT, 1'b0, 1'b0},
        '{KIND_WRITE, LANE_UNLOCK1, 32'h0000_0AA7, PROG_SETUP,  1'b0, 1'b0},
        '{KIND_WRITE, 2'd1,         32'h0000_0000, 32'h0000_00FF, 1'b0, 1'b1},
        // finish after a timed-out poll
        '{KIND_FINISH, 2'd0, 32'h0, 32'h0, 1'b1, 1'b1}
    };

    // Settings loaded by the directed rows marked reconfig, in order.
    localparam cfg_set_t DIRECTED_CFG [2] = '{
        '{32'hFFFF_FFFF, 20'd0,      26'd0},  // wrap, zero thresholds
        '{32'h0000_0000, 20'hF_FFFF, 26'd1}   // done unreachable, timeouts only
    };

    localparam int N_DIRECTED = 26;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // reset settings
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'hFFFF_FFFF, 17'd1, 1'b0, 1'b1, 4'd0, 3'd0},
        '{CMD_NONE,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,         17'd1, 1'b0, 1'b1, 4'd0, 3'd0},
        '{CMD_ERASE,   32'hFFFF_FFFF, 32'h0,         32'h0,         17'd1, 1'b0, 1'b1, 4'd0, 3'd6},
        '{CMD_ERASE,   32'h1234_5678, 32'h0,         32'h0,         17'd1, 1'b0, 1'b1, 4'd0, 3'd0},
        '{CMD_PROGRAM, 32'h0,         32'hFFFF_FFFF, 32'h0,         17'd1, 1'b0, 1'b1, 4'd0, 3'd0},
        '{CMD_NONE,    32'h0,         32'h0,         32'hFFFF_FFFF, 17'd1, 1'b0, 1'b1, 4'd0, 3'd0},
        // a few repeats stay far below the default stable_reads
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h0000_00FF, 17'd3, 1'b0, 1'b1, 4'd0, 3'd0},
        // wrapping base, zero stable_reads and change_limit, loaded mid-poll
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h0000_00FF, 17'd1, 1'b1, 1'b1, 4'd6, 3'd1},
        '{CMD_PROGRAM, 32'h0,         32'hFFFF_FFFF, 32'h0,         17'd1, 1'b0, 1'b1, 4'd7, 3'd4},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h0,         17'd1, 1'b0, 1'b1, 4'd11, 3'd4},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h0,         17'd1, 1'b0, 1'b0, 4'd0, 3'd0},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h0000_00FF, 17'd1, 1'b0, 1'b0, 4'd0, 3'd0},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h1234_5678, 17'd1, 1'b0, 1'b1, 4'd6, 3'd1},
        // done out of reach, change_limit 1: every poll ends as timeout
        '{CMD_ERASE,   32'h0,         32'h0,         32'h0,         17'd1, 1'b1, 1'b0, 4'd0, 3'd0},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h0000_00FF, 17'd1, 1'b0, 1'b0, 4'd0, 3'd0},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h0,         17'd1, 1'b0, 1'b0, 4'd0, 3'd0},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'hFFFF_FFFF, 17'd1, 1'b0, 1'b1, 4'd15, 3'd1},
        '{CMD_PROGRAM, 32'hFFFF_FFFF, 32'h0,         32'h0,         17'd1, 1'b0, 1'b0, 4'd0, 3'd0},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h0,         17'd1, 1'b0, 1'b0, 4'd0, 3'd0},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h1,         17'd1, 1'b0, 1'b0, 4'd0, 3'd0},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h1,         17'd1, 1'b0, 1'b0, 4'd0, 3'd0},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h2,         17'd1, 1'b0, 1'b0, 4'd0, 3'd0},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h0,         17'd1, 1'b0, 1'b0, 4'd0, 3'd0},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'hFFFF_FFFF, 17'd1, 1'b0, 1'b0, 4'd0, 3'd0},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h8000_0000, 17'd1, 1'b0, 1'b0, 4'd0, 3'd0},
        '{CMD_SAMPLE,  32'h0,         32'h0,         32'h7FFF_FFFF, 17'd1, 1'b0, 1'b1, 4'd15, 3'd1}
    };

    // ------------------------------------------------------------------
    // Clock, reset, configuration port and channels
    // ------------------------------------------------------------------
    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    word_t    cfg_wdata;

    pfcs_req_if req_ch ();
    pfcs_rsp_if rsp_ch ();

    parallel_flash_command_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Sequencer predictor: own copy of settings and state
    // ------------------------------------------------------------------
    addr_t      win_base;
    stable_t    stable_lim;
    change_t    change_lim;

    seq_phase_t seq_phase;
    logic       prog_op;
    lane_t      byte_sel;
    addr_t      op_addr;
    word_t      op_word;
    word_t      prev_status;
    stable_t    same_run;
    change_t    change_run;
    logic       tmo_flag;

    flash_result_t beat_results [$];     // results of the beat just predicted
    flash_result_t awaited_results [$];  // results not yet seen on rsp

    // Scoreboard and run bookkeeping
    int mismatches;
    int items_sent;
    int results_checked;
    int ops_finished;
    int ops_timed_out;
    int cycle_count;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_asked;
    int hold_taken;
    int hold_left;

    function automatic void reset_predictor();
        win_base    = FLASH_BASE_RST;
        stable_lim  = STABLE_READS_RST;
        change_lim  = CHANGE_LIMIT_RST;
        seq_phase   = SEQ_IDLE;
        prog_op     = 1'b0;
        byte_sel    = 2'd0;
        op_addr     = '0;
        op_word     = '0;
        prev_status = SAMPLE_RST;
        same_run    = '0;
        change_run  = '0;
        tmo_flag    = 1'b0;
    endfunction

    function automatic void add_write(lane_t lane, addr_t addr, word_t data);
        flash_result_t r;
        r.kind      = KIND_WRITE;
        r.lane      = lane;
        r.bus_addr  = addr;
        r.bus_data  = data;
        r.timed_out = 1'b0;
        r.last      = 1'b0;
        beat_results.push_back(r);
    endfunction

    function automatic void begin_poll();
        seq_phase   = SEQ_POLL;
        prev_status = SAMPLE_RST;
        same_run    = '0;
        change_run  = '0;
    endfunction

    // Unlock, program setup and the data byte on its own lane, then poll.
    function automatic void program_byte();
        word_t data;
        data = (op_word >> (8 * byte_sel)) & 32'h0000_00FF;
        add_write(LANE_UNLOCK1, win_base + UNLOCK1_OFS, UNLOCK1_DAT);
        add_write(LANE_UNLOCK2, win_base + UNLOCK2_OFS, UNLOCK2_DAT);
        add_write(LANE_UNLOCK1, win_base + UNLOCK1_OFS, PROG_SETUP);
        add_write(byte_sel, op_addr, data);
        begin_poll();
    endfunction

    // Advance the predicted state by one accepted command beat and leave
    // the results it causes in beat_results.
    function automatic void sequence_beat(cmd_t cmd, addr_t taddr, word_t wdata,
                                          word_t status);
        int unsigned   run;
        int unsigned   changes;
        logic          done;
        logic          tmo;
        flash_result_t fin;
        beat_results.delete();
        if (seq_phase == SEQ_IDLE)
        begin
            if (cmd == CMD_ERASE)
            begin
                prog_op  = 1'b0;
                op_addr  = taddr;
                tmo_flag = 1'b0;
                add_write(LANE_UNLOCK1, win_base + UNLOCK1_OFS, UNLOCK1_DAT);
                add_write(LANE_UNLOCK2, win_base + UNLOCK2_OFS, UNLOCK2_DAT);
                add_write(LANE_UNLOCK1, win_base + UNLOCK1_OFS, ERASE_SETUP);
                add_write(LANE_UNLOCK1, win_base + UNLOCK1_OFS, UNLOCK1_DAT);
                add_write(LANE_UNLOCK2, win_base + UNLOCK2_OFS, UNLOCK2_DAT);
                add_write(LANE_SECTOR, taddr, ERASE_CONFIRM);
                begin_poll();
            end
            else if (cmd == CMD_PROGRAM)
            begin
                prog_op  = 1'b1;
                op_addr  = taddr;
                op_word  = wdata;
                byte_sel = 2'd0;
                tmo_flag = 1'b0;
                program_byte();
            end
        end
        else if (cmd == CMD_SAMPLE)
        begin
            run     = 32'(same_run);
            changes = 32'(change_run);
            if (status != prev_status)
            begin
                changes++;
                run = 0;
            end
            prev_status = status;
            run++;
            // done wins when both thresholds are crossed by the same sample
            done = run > 32'(stable_lim);
            tmo  = !done && changes > 32'(change_lim);
            if (!done && !tmo)
            begin
                same_run   = stable_t'(run);
                change_run = change_t'(changes);
            end
            else
            begin
                if (tmo)
                    tmo_flag = 1'b1;
                same_run   = '0;
                change_run = '0;
                if (prog_op && byte_sel < 2'd3)
                begin
                    byte_sel = byte_sel + 2'd1;
                    program_byte();
                end
                else
                begin
                    fin           = '0;
                    fin.kind      = KIND_FINISH;
                    fin.timed_out = tmo_flag;
                    beat_results.push_back(fin);
                    seq_phase = SEQ_IDLE;
                end
            end
        end
        if (beat_results.size() > 0)
            beat_results[beat_results.size() - 1].last = 1'b1;
    endfunction

    // Status for a random poll beat: mostly a repeat, so polls can settle.
    function automatic word_t next_status();
        if ($urandom_range(99) < 70)
            return prev_status;
        if ($urandom_range(1) == 1)
            return $urandom;
        return prev_status ^ (32'h1 << $urandom_range(31));
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Offer one command beat, hold it until taken, then predict its results.
    // Typed rows replace the predicted results with the ones from the table.
    task automatic send_item(input cmd_t cmd, input addr_t taddr, input word_t wdata,
                             input word_t status, input bit typed, input int first,
                             input int count);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= cmd;
        req_ch.target_addr <= taddr;
        req_ch.data_in     <= wdata;
        req_ch.sample      <= status;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        sequence_beat(cmd, taddr, wdata, status);
        if (typed)
        begin
            for (int j = 0; j < count; j++)
                awaited_results.push_back(TYPED_RESULTS[first + j]);
        end
        else
        begin
            foreach (beat_results[j])
                awaited_results.push_back(beat_results[j]);
        end
    endtask

    // Drop valid and hold until every predicted result has come out, then
    // give the block a few more cycles to settle.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Load all three registers, one per cycle; the caller makes sure no
    // result is pending.
    task automatic apply_settings(input addr_t base, input stable_t stable,
                                  input change_t change);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FLASH_BASE;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_index <= CFG_STABLE_READS;
        cfg_wdata <= word_t'(stable);
        @(posedge clk);
        cfg_index <= CFG_CHANGE_LIMIT;
        cfg_wdata <= word_t'(change);
        @(posedge clk);
        cfg_we     <= 1'b0;
        win_base   = base;
        stable_lim = stable;
        change_lim = change;
    endtask

    // Feed status beats until the open operation finishes: repeats where
    // the stable threshold is the nearer one, flips otherwise.
    task automatic finish_operation();
        while (seq_phase == SEQ_POLL)
            send_item(CMD_SAMPLE, $urandom, $urandom,
                      (stable_lim < change_lim) ? prev_status : ~prev_status, 1'b0, 0, 0);
    endtask

    // Random traffic: mostly well-formed erase/program runs followed by
    // polls, with ignored commands mixed in. Only beats that matter count.
    task automatic run_phase(input int target, input int hold_at, input int pause_at);
        int   taken;
        bit   hold_done;
        bit   pause_done;
        cmd_t noise;
        taken      = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        while (taken < target)
        begin
            if (!hold_done && taken == hold_at)
            begin
                hold_asked++;
                hold_done = 1'b1;
            end
            if (!pause_done && taken == pause_at)
            begin
                wait_drained();
                pause_done = 1'b1;
            end
            if (seq_phase == SEQ_IDLE)
            begin
                if ($urandom_range(99) < 12)
                begin
                    noise = ($urandom_range(1) == 1) ? CMD_SAMPLE : CMD_NONE;
                    send_item(noise, $urandom, $urandom, $urandom, 1'b0, 0, 0);
                end
                else
                begin
                    send_item(($urandom_range(99) < 40) ? CMD_ERASE : CMD_PROGRAM,
                              $urandom, $urandom, $urandom, 1'b0, 0, 0);
                    taken++;
                end
            end
            else if ($urandom_range(99) < 10)
            begin
                case ($urandom_range(2))
                    0:       noise = CMD_ERASE;
                    1:       noise = CMD_PROGRAM;
                    default: noise = CMD_NONE;
                endcase
                send_item(noise, $urandom, $urandom, $urandom, 1'b0, 0, 0);
            end
            else
            begin
                send_item(CMD_SAMPLE, $urandom, $urandom, next_status(), 1'b0, 0, 0);
                taken++;
            end
        end
        finish_operation();
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, long hold-off on request, and the check
    // of every taken beat against the oldest awaited result.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        flash_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result beat: kind %0d addr 0x%08h data 0x%08h",
                         $time, rsp_ch.kind, rsp_ch.bus_addr, rsp_ch.bus_data);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                results_checked++;
                check_field("kind",      32'(want.kind),      32'(rsp_ch.kind));
                check_field("lane",      32'(want.lane),      32'(rsp_ch.lane));
                check_field("bus_addr",  want.bus_addr,       rsp_ch.bus_addr);
                check_field("bus_data",  want.bus_data,       rsp_ch.bus_data);
                check_field("timed_out", 32'(want.timed_out), 32'(rsp_ch.timed_out));
                check_field("last",      32'(want.last),      32'(rsp_ch.last));
                if (want.kind == KIND_FINISH)
                begin
                    ops_finished++;
                    if (want.timed_out)
                        ops_timed_out++;
                end
            end
        end
        // Pick up a new hold-off request, otherwise stall at the phase rate.
        if (hold_taken != hold_asked)
        begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= !(receiver_stall_pct > 0 &&
                              $urandom_range(99) < receiver_stall_pct);
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, awaited_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int cfg_sel;
        cfg_sel            = 0;
        mismatches         = 0;
        items_sent         = 0;
        results_checked    = 0;
        ops_finished       = 0;
        ops_timed_out      = 0;
        cycle_count        = 0;
        hold_asked         = 0;
        hold_taken         = 0;
        hold_left          = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;

        // Hold every input at a known value through reset.
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_FLASH_BASE;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_NONE;
        req_ch.target_addr = '0;
        req_ch.data_in     = '0;
        req_ch.sample      = '0;
        rsp_ch.ready       = 1'b0;
        reset_predictor();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows: reset settings first (an erase whose poll stays
        // open), then the wrapping base with zero thresholds, which closes
        // that poll, then a setting where every poll has to time out.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].reconfig)
            begin
                wait_drained();
                apply_settings(DIRECTED_CFG[cfg_sel].base, DIRECTED_CFG[cfg_sel].stable,
                               DIRECTED_CFG[cfg_sel].change);
                cfg_sel++;
            end
            for (int k = 1; k <= int'(DIRECTED[i].reps); k++)
                send_item(DIRECTED[i].cmd, DIRECTED[i].taddr, DIRECTED[i].wdata,
                          DIRECTED[i].status,
                          DIRECTED[i].typed && k == int'(DIRECTED[i].reps),
                          int'(DIRECTED[i].first), int'(DIRECTED[i].count));
        end

        // Random phases: each starts from an idle, drained block with fresh
        // settings and its own idling pattern.
        wait_drained();
        apply_settings($urandom, 20'd1, 26'd2);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        run_phase(70, -1, -1);

        // Base near the top of the space; change_limit at its maximum.
        wait_drained();
        apply_settings(32'hFFFF_F000, 20'd2, 26'h3FF_FFFF);
        sender_idle_pct    = 47;
        receiver_stall_pct = 0;
        run_phase(70, -1, -1);

        // Receiver stalls, plus one long hold-off that backs up the command side.
        wait_drained();
        apply_settings($urandom, 20'd0, 26'd3);
        sender_idle_pct    = 0;
        receiver_stall_pct = 47;
        run_phase(60, 20, -1);

        // Light idling on both sides; the sender pauses once until drained.
        wait_drained();
        apply_settings($urandom, 20'd3, 26'd1);
        sender_idle_pct    = 7;
        receiver_stall_pct = 7;
        run_phase(70, -1, 40);

        // stable_reads at its maximum: every poll ends on the first change.
        wait_drained();
        apply_settings($urandom, 20'hF_FFFF, 26'd0);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        run_phase(35, -1, -1);

        wait_drained();

        $display("Run covered %0d command beats and %0d result beats checked,",
                 items_sent, results_checked);
        $display("with %0d operations finished, %0d of them after a poll timeout.",
                 ops_finished, ops_timed_out);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
